/* rtl/burning_ship_escape_time_top_assert.svh */
// Assertion macros for the burning ship escape-time block.
`ifndef BURNING_SHIP_ESCAPE_TIME_TOP_ASSERT_SVH
`define BURNING_SHIP_ESCAPE_TIME_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define BSET_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define BSET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSET_ASSERT_IMPL(lbl, ante, cons, msg)
`define BSET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/bset_pkg.sv */
// Package: constants, types and helpers of the burning ship escape-time block.
package bset_pkg;

    localparam int FRAC_BITS   = 26;
    localparam int Z_W         = 32;
    localparam int PROD_W      = 2 * Z_W;
    localparam int CNT_W       = 16;
    localparam int THRESH_BITS = 2 * FRAC_BITS + 2;
    localparam bit THRESH_ON   = (THRESH_BITS < PROD_W);

    localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(64);
    localparam logic [Z_W-1:0]    MAG_MIN     = 32'h8000_0000;
    localparam logic [Z_W-1:0]    MAG_MAX     = 32'h7FFF_FFFF;
    // (2^31 - 1)^2, the square of a saturated magnitude
    localparam logic [PROD_W-1:0] SAT_SQ      = 64'h3FFF_FFFF_0000_0001;
    localparam logic [PROD_W-1:0] ESC_THRESH  =
        THRESH_ON ? (PROD_W'(1) << (THRESH_ON ? THRESH_BITS : 0)) : '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_R,
        ST_SQ_I,
        ST_CROSS,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OPSEL_RR,
        OPSEL_II,
        OPSEL_AB
    } opsel_t;

    typedef struct packed {
        logic   in_ready;
        logic   load;
        opsel_t opsel;
        logic   cap_sqr;
        logic   cap_sqi;
        logic   step;
        logic   emit;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic stop;
        logic out_free;
    } status_t;

    // Clamp a 65-bit signed sum to the 32-bit signed range.
    function automatic logic [Z_W-1:0] sat32(input logic [PROD_W:0] v);
        logic neg;
        logic all_ones;
        logic all_zeros;
        logic [Z_W-1:0] r;
        neg       = v[PROD_W];
        all_ones  = &v[PROD_W:Z_W-1];
        all_zeros = ~|v[PROD_W:Z_W-1];
        if (neg && !all_ones) begin
            r = MAG_MIN;
        end else if (!neg && !all_zeros) begin
            r = MAG_MAX;
        end else begin
            r = v[Z_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/bset_mul.sv */
// Shared 32x32 unsigned multiplier with a registered product.
module bset_mul (
    input  logic                      clk,
    input  logic [bset_pkg::Z_W-1:0]  op_a,
    input  logic [bset_pkg::Z_W-1:0]  op_b,
    output logic [bset_pkg::PROD_W-1:0] prod
);
    import bset_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* rtl/bset_ctrl.sv */
// Sequencer: steps one point through square, square, cross product and check.
module bset_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  bset_pkg::status_t status,
    output bset_pkg::ctrl_t   ctrl
);
    import bset_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.opsel = OPSEL_RR;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (status.in_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_SQ_R;
                end
            end
            ST_SQ_R:
            begin
                ctrl.opsel = OPSEL_RR;
                state_next = ST_SQ_I;
            end
            ST_SQ_I:
            begin
                ctrl.opsel   = OPSEL_II;
                ctrl.cap_sqr = 1'b1;
                state_next   = ST_CROSS;
            end
            ST_CROSS:
            begin
                ctrl.opsel   = OPSEL_AB;
                ctrl.cap_sqi = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.stop) begin
                    state_next = ST_FINISH;
                end else begin
                    ctrl.step  = 1'b1;
                    state_next = ST_SQ_R;
                end
            end
            ST_FINISH:
            begin
                // hold until the result register is free
                if (status.out_free) begin
                    ctrl.emit  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/burning_ship_escape_time_top.sv */
// Top level of the burning ship escape-time block: datapath, sequencer and result register.
//
// Takes one point c = (point_real, point_imag), signed Q6.26, and iterates the burning
// ship recurrence z = (|Re z| + i|Im z|)^2 + c from z = 0 until |z|^2 >= 4 or the pass
// count reaches iteration_limit; escape_count returns that count. All arithmetic is
// fixed point: squares and the cross product are exact 64-bit values, then truncated
// toward minus infinity back to the point format, and each new part of z saturates
// to 32 bits. One multiplier is shared by every product: a pass issues |Re z|^2,
// |Im z|^2 and the saturated cross product in turn, in ST_SQ_R, ST_SQ_I and ST_CROSS,
// and tests in ST_CHECK; a finished point goes through ST_FINISH back to idle before
// the next word can be taken. The input takes a new word only while no point is in
// flight; a finished result waits in its own register, so the next point may start
// while it is still unread, and a second finished point holds until that register
// is free. iteration_limit is written through cfg_write_en / cfg_write_data and must
// only be changed while the block is idle; a limit of zero returns zero for every point.
`include "burning_ship_escape_time_top_assert.svh"

module burning_ship_escape_time_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [bset_pkg::CNT_W-1:0] cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [bset_pkg::Z_W-1:0] point_real,
    input  logic signed [bset_pkg::Z_W-1:0] point_imag,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bset_pkg::CNT_W-1:0] escape_count
);
    import bset_pkg::*;

    // control
    ctrl_t   ctrl;
    status_t status;

    // configuration
    logic [CNT_W-1:0] limit_reg;

    // per-point scratch
    logic [Z_W-1:0]    cr_reg, cr_next;
    logic [Z_W-1:0]    ci_reg, ci_next;
    logic [Z_W-1:0]    zr_reg, zr_next;
    logic [Z_W-1:0]    zi_reg, zi_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PROD_W-1:0] sqr_reg, sqr_next;
    logic [PROD_W-1:0] sqi_reg, sqi_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] escape_count_reg, escape_count_next;

    // datapath wires
    logic [Z_W-1:0]    mag_r, mag_i;
    logic [Z_W-1:0]    sat_r, sat_i;
    logic [Z_W-1:0]    op_a, op_b;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] mag_sum;
    logic              escape;
    logic [PROD_W-1:0] a_sq, b_sq;
    logic [PROD_W-1:0] diff;
    logic [PROD_W-1:0] diff_shr;
    logic [PROD_W-1:0] cross_dbl;
    logic [PROD_W-1:0] cross_shr;
    logic [PROD_W:0]   nr_wide, ni_wide;

    bset_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    bset_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Magnitudes of z; -2^31 gives 2^31 here, saturated to 2^31 - 1 for the cross product.
    assign mag_r = zr_reg[Z_W-1] ? (~zr_reg + Z_W'(1)) : zr_reg;
    assign mag_i = zi_reg[Z_W-1] ? (~zi_reg + Z_W'(1)) : zi_reg;
    assign sat_r = (mag_r == MAG_MIN) ? MAG_MAX : mag_r;
    assign sat_i = (mag_i == MAG_MIN) ? MAG_MAX : mag_i;

    always_comb
    begin
        unique case (ctrl.opsel)
            OPSEL_RR:
            begin
                op_a = mag_r;
                op_b = mag_r;
            end
            OPSEL_II:
            begin
                op_a = mag_i;
                op_b = mag_i;
            end
            OPSEL_AB:
            begin
                op_a = sat_r;
                op_b = sat_i;
            end
            default:
            begin
                op_a = mag_r;
                op_b = mag_r;
            end
        endcase
    end

    // Escape test on the exact squares; both are at most 2^62, so the sum fits.
    assign mag_sum = sqr_reg + sqi_reg;
    assign escape  = THRESH_ON && (mag_sum >= ESC_THRESH);

    assign status.in_valid = in_valid;
    assign status.stop     = (count_reg >= limit_reg) || escape;
    assign status.out_free = !out_valid_reg || out_ready;

    // New real part: squares of the saturated magnitudes, floor shift, add c.
    assign a_sq      = (mag_r == MAG_MIN) ? SAT_SQ : sqr_reg;
    assign b_sq      = (mag_i == MAG_MIN) ? SAT_SQ : sqi_reg;
    assign diff      = a_sq - b_sq;
    assign diff_shr  = PROD_W'($signed(diff) >>> FRAC_BITS);
    assign nr_wide   = {diff_shr[PROD_W-1], diff_shr}
                     + {{(PROD_W-Z_W+1){cr_reg[Z_W-1]}}, cr_reg};

    // New imaginary part: cross product (held in the multiplier) doubled and shifted.
    assign cross_dbl = {prod[PROD_W-2:0], 1'b0};
    assign cross_shr = cross_dbl >> FRAC_BITS;
    assign ni_wide   = {1'b0, cross_shr}
                     + {{(PROD_W-Z_W+1){ci_reg[Z_W-1]}}, ci_reg};

    always_comb
    begin
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        count_next = count_reg;
        sqr_next   = sqr_reg;
        sqi_next   = sqi_reg;
        if (ctrl.load) begin
            cr_next    = point_real;
            ci_next    = point_imag;
            zr_next    = '0;
            zi_next    = '0;
            count_next = '0;
        end
        if (ctrl.cap_sqr) begin
            sqr_next = prod;
        end
        if (ctrl.cap_sqi) begin
            sqi_next = prod;
        end
        if (ctrl.step) begin
            zr_next    = sat32(nr_wide);
            zi_next    = sat32(ni_wide);
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        escape_count_next = escape_count_reg;
        out_valid_next    = out_valid_reg;
        if (ctrl.emit) begin
            escape_count_next = count_reg;
            out_valid_next    = 1'b1;
        end else if (out_ready) begin
            // drop the word once it is taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_write_en) begin
                limit_reg <= cfg_write_data;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_reg           <= cr_next;
        ci_reg           <= ci_next;
        zr_reg           <= zr_next;
        zi_reg           <= zi_next;
        sqr_reg          <= sqr_next;
        sqi_reg          <= sqi_next;
        escape_count_reg <= escape_count_next;
    end

    assign in_ready     = ctrl.in_ready;
    assign out_valid    = out_valid_reg;
    assign escape_count = escape_count_reg;

    // The pass count never runs past the limit while a point is in flight.
    `BSET_ASSERT_IMPL(a_count_in_limit, !ctrl.in_ready, count_reg <= limit_reg,
        "pass count exceeds iteration limit")
    // An accepted point starts from z = 0 with a zero count.
    `BSET_ASSERT_NEXT(a_load_clears, in_valid && in_ready,
        count_reg == '0 && zr_reg == '0 && zi_reg == '0, "point did not start from zero")
    // A result is only written into a free result register, and then shows as valid.
    `BSET_ASSERT_NEXT(a_emit_valid, ctrl.emit, out_valid && escape_count == $past(count_reg),
        "result register lost the finished count")
    // A pass is only taken below the limit and before escape.
    `BSET_ASSERT_IMPL(a_step_allowed, ctrl.step, count_reg < limit_reg && !escape,
        "pass taken after the loop should have stopped")

endmodule

/* test/burning_ship_escape_time_checker.sv */
// Scoreboard for the burning ship escape-time block: predicts each escape count and compares.
`timescale 1ns / 1ps

module burning_ship_escape_time_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [bset_pkg::CNT_W-1:0]      cfg_write_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic signed [bset_pkg::Z_W-1:0] point_real,
    input  logic signed [bset_pkg::Z_W-1:0] point_imag,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [bset_pkg::CNT_W-1:0]      escape_count,
    output int                              mismatches,
    output int                              outstanding,
    output int                              counts_checked
);
    import bset_pkg::*;

    typedef struct {
        logic signed [Z_W-1:0] re;
        logic signed [Z_W-1:0] im;
        logic [CNT_W-1:0]      passes;
    } escape_forecast_t;

    localparam longint          Z_HI    = 2147483647;
    localparam longint          Z_LO    = -Z_HI - 1;
    localparam longint unsigned MAG_CAP = 2147483647;
    localparam int              LOG_CAP = 40;

    escape_forecast_t escape_forecast[$];
    escape_forecast_t due;
    logic [CNT_W-1:0] limit_now = LIMIT_RESET;
    int               error_total = 0;
    int               checked_total = 0;

    function automatic longint clamp_z(input longint v);
        if (v > Z_HI)
            return Z_HI;
        if (v < Z_LO)
            return Z_LO;
        return v;
    endfunction

    // Iterate the recurrence from z = 0 and return the passes made.
    function automatic logic [CNT_W-1:0] ship_escape_count(
        input logic signed [Z_W-1:0] cr,
        input logic signed [Z_W-1:0] ci,
        input logic [CNT_W-1:0]      limit
    );
        longint          zr;
        longint          zi;
        longint          diff;
        longint unsigned ar;
        longint unsigned ai;
        longint unsigned a;
        longint unsigned b;
        int unsigned     passes;
        zr = 0;
        zi = 0;
        passes = 0;
        while (passes < limit)
        begin
            ar = (zr < 0) ? -zr : zr;
            ai = (zi < 0) ? -zi : zi;
            if (THRESH_ON && (ar * ar + ai * ai >= ESC_THRESH))
                break;
            a = (ar > MAG_CAP) ? MAG_CAP : ar;
            b = (ai > MAG_CAP) ? MAG_CAP : ai;
            diff = longint'(a * a) - longint'(b * b);
            zr = clamp_z((diff >>> FRAC_BITS) + longint'(cr));
            zi = clamp_z(longint'(((a * b) << 1) >> FRAC_BITS) + longint'(ci));
            passes++;
        end
        return CNT_W'(passes);
    endfunction

    task automatic report_mismatch(input string what);
        // cap the log, keep counting
        if (error_total < LOG_CAP)
            $display("[%0t] escape count error: %s", $time, what);
        error_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_now = LIMIT_RESET;
            escape_forecast.delete();
        end
        else
        begin
            if (cfg_write_en)
                limit_now = cfg_write_data;
            if (out_valid && out_ready)
            begin
                if (escape_forecast.size() == 0)
                    report_mismatch($sformatf("count %0d with no point waiting", escape_count));
                else
                begin
                    due = escape_forecast.pop_front();
                    checked_total++;
                    if (escape_count !== due.passes)
                        report_mismatch($sformatf("point (%h, %h) gave %0d, predicted %0d",
                            due.re, due.im, escape_count, due.passes));
                end
            end
            if (in_valid && in_ready)
                escape_forecast.push_back('{point_real, point_imag,
                    ship_escape_count(point_real, point_imag, limit_now)});
        end
        mismatches     <= error_total;
        outstanding    <= escape_forecast.size();
        counts_checked <= checked_total;
    end

endmodule

/* test/burning_ship_escape_time_top_test.sv */
// Testbench top for the burning ship escape-time block: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module burning_ship_escape_time_top_test;
    import bset_pkg::*;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    // One unit in the point format.
    localparam int Q_ONE            = 1 << FRAC_BITS;
    // Long receiver hold-off so the result register and the in-flight point back up.
    localparam int HOLD_CYCLES      = 500;
    // A never-escaping point at the top limit keeps both channels quiet for its whole run.
    localparam int WATCHDOG_CYCLES  = 1000000;
    // Idle time after the last count has come back.
    localparam int SETTLE_CYCLES    = 300;
    localparam int RANDOM_PHASES    = 6;
    localparam int POINTS_PER_PHASE = 225;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CNT_W-1:0]      cfg_write_data;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [Z_W-1:0] point_real;
    logic signed [Z_W-1:0] point_imag;
    logic                  out_valid;
    logic                  out_ready;
    logic [CNT_W-1:0]      escape_count;

    int    mismatches;
    int    outstanding;
    int    counts_checked;
    pace_t pace;
    logic  hold_wanted;
    int    hold_count = 0;
    int    quiet_cycles = 0;
    int    points_sent = 0;

    always #6 clk = ~clk;

    burning_ship_escape_time_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .point_real     (point_real),
        .point_imag     (point_imag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .escape_count   (escape_count)
    );

    burning_ship_escape_time_checker count_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .point_real     (point_real),
        .point_imag     (point_imag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .escape_count   (escape_count),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .counts_checked (counts_checked)
    );

    // Result side: stall at the pace of the current phase; once asked, hold off
    // for a fixed stretch counted here, then fall back to normal pacing.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_wanted && hold_count < HOLD_CYCLES)
        begin
            out_ready  <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else if (pace == PACE_RECEIVER_STALL)
            out_ready <= ($urandom_range(99) >= 65);
        else if (pace == PACE_BOTH)
            out_ready <= ($urandom_range(99) >= 13);
        else
            out_ready <= 1'b1;
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("burning_ship_escape_time_top: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one point and return at the edge that accepts it. Valid stays high on
    // return; the next call either keeps it up or drops it for an idle gap.
    task automatic send_point(input logic [Z_W-1:0] re, input logic [Z_W-1:0] im);
        int gap_pct;
        gap_pct = (pace == PACE_SENDER_IDLE) ? 65 : (pace == PACE_BOTH) ? 13 : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid   <= 1'b1;
        point_real <= re;
        point_imag <= im;
        do
            @(posedge clk);
        while (!in_ready);
        points_sent++;
    endtask

    // Drop valid, wait until every predicted count has come back, then let the
    // block sit idle for a while.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the limit on an idle block and switch pacing for the next phase.
    task automatic start_phase(input logic [CNT_W-1:0] limit, input pace_t mode);
        settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= limit;
        pace           <= mode;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [CNT_W-1:0]      phase_limit [RANDOM_PHASES];
        pace_t                 phase_pace  [RANDOM_PHASES];
        logic signed [Z_W-1:0] re;
        logic signed [Z_W-1:0] im;
        int unsigned           pick;

        phase_limit = '{16'd64, 16'd0, 16'd255, 16'd16, 16'd3, 16'd100};
        phase_pace  = '{PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH,
                        PACE_SENDER_IDLE, PACE_RECEIVER_STALL};

        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        point_real     <= '0;
        point_imag     <= '0;
        pace           <= PACE_FULL;
        hold_wanted    <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at the reset limit.
        send_point(32'h0000_0000, 32'h0000_0000);   // origin, never escapes
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // both parts at the top
        send_point(32'h8000_0000, 32'h8000_0000);   // both parts at the bottom
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h0000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h0000_0000);
        send_point(32'h0000_0001, 32'h0000_0001);   // one lsb each
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // minus one lsb each
        send_point(32'hF800_0000, 32'h0000_0000);   // -2: |z|^2 lands exactly on 4
        send_point(32'h0800_0000, 32'h0000_0000);   // +2
        send_point(32'h0000_0000, 32'hF800_0000);   // -2i
        send_point(32'h07FF_FFFF, 32'h0000_0000);   // just under 2
        send_point(32'hFC00_0000, 32'h0000_0000);   // -1: orbit swaps between 0 and -1
        send_point(32'hF900_0000, 32'hFFE1_47AE);   // inside the ship's antenna
        send_point(32'h0100_0000, 32'h0000_0000);   // 0.25: cusp, very slow
        send_point(32'h0133_3333, 32'h0000_0000);   // 0.3: slow escape
        send_point(32'hFE00_0000, 32'hFE00_0000);   // -0.5 - 0.5i

        // Zero limit: every point returns zero.
        start_phase(16'd0, PACE_FULL);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point($urandom, $urandom);

        // Single pass.
        start_phase(16'd1, PACE_FULL);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);

        // Top limit: one full-length orbit, plus points that leave at once.
        start_phase(16'hFFFF, PACE_FULL);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point($urandom, $urandom);

        // Back-pressure: hold the receiver off while fast escapers keep coming,
        // so the result register fills and the input stalls.
        start_phase(LIMIT_RESET, PACE_FULL);
        hold_wanted <= 1'b1;
        repeat (12)
            send_point(32'h1000_0000 | $urandom_range(16'hFFFF), $urandom);

        // Random points across several limits and pacing modes.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            start_phase((p == 1) ? CNT_W'($urandom_range(128, 1)) : phase_limit[p],
                        phase_pace[p]);
            for (int n = 0; n < POINTS_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    // the plane around the whole ship
                    re = -(5 * Q_ONE / 2) + int'($urandom_range(4 * Q_ONE));
                    im = -(2 * Q_ONE) + int'($urandom_range(3 * Q_ONE));
                end
                else if (pick < 80)
                begin
                    // the main body, where orbits run long
                    re = -Q_ONE + int'($urandom_range(3 * Q_ONE / 2));
                    im = -Q_ONE + int'($urandom_range(6 * Q_ONE / 5));
                end
                else
                begin
                    // anywhere in the 32-bit range
                    re = $urandom;
                    im = $urandom;
                end
                send_point(re, im);
            end
        end

        settle();
        $display("Sent %0d points; limits 0, 1, 3, 16, 64, 100, 255, 65535 and one random.",
                 points_sent);
        $display("Checked %0d counts under full rate, idle, stall and a %0d-cycle hold-off.",
                 counts_checked, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("burning_ship_escape_time_top: match");
        else
            $display("burning_ship_escape_time_top: mismatch");
        $finish;
    end

endmodule
